[design/sidta_pkg.sv]
`timescale 1ns / 1ps

package sidta_pkg;

   localparam int NumBits    = 16;
   localparam int NumDigits  = 5;
   localparam int DigitW     = 4;
   localparam int BcdW       = NumDigits * DigitW;
   localparam int DigitIdxW  = 3;
   localparam int StepCntW   = 4;
   localparam int CharW      = 7;

   localparam logic [StepCntW-1:0] StepLast   = StepCntW'(NumBits - 1);
   localparam logic [CharW-1:0]    AsciiMinus = 7'd45;
   localparam logic [CharW-1:0]    AsciiZero  = 7'd48;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_PREP,
      ST_SIGN,
      ST_DIGITS
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic shift;
      logic prep;
      logic next_digit;
      logic emit_sign;
   } ctrl_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic shift_done;
      logic neg;
      logic last_digit;
   } dp_status_type;

endpackage

[design/sidta_dp.sv]
`timescale 1ns / 1ps

module sidta_dp import sidta_pkg::*; (
   input  logic                 clock,
   input  logic [NumBits-1:0]   number_in,
   input  ctrl_cmd_type         cmd,
   output dp_status_type        status,
   output logic [CharW-1:0]     char_code
);

   logic [NumBits-1:0]   bin_ff,  bin_in;
   logic [BcdW-1:0]      bcd_ff,  bcd_in;
   logic                 neg_ff,  neg_in;
   logic [StepCntW-1:0]  cnt_ff,  cnt_in;
   logic [DigitIdxW-1:0] idx_ff,  idx_in;

   logic [BcdW-1:0]      bcd_adj;
   logic [DigitIdxW-1:0] lead_idx;
   logic [DigitW-1:0]    cur_digit;
   logic [DigitW-1:0]    dig;

   // Add-3 correction on every BCD digit before each shift.
   always_comb begin
      for (int i = 0; i < NumDigits; i++) begin
         dig = bcd_ff[i*DigitW +: DigitW];
         bcd_adj[i*DigitW +: DigitW] = (dig >= 4'd5) ? dig + 4'd3 : dig;
      end
   end

   // Position of the most significant nonzero digit, zero if all are zero.
   always_comb begin
      lead_idx = '0;
      for (int i = 0; i < NumDigits; i++) begin
         if (bcd_ff[i*DigitW +: DigitW] != '0) begin
            lead_idx = DigitIdxW'(i);
         end
      end
   end

   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      if (cmd.load) begin
         neg_in = number_in[NumBits-1];
         bin_in = number_in[NumBits-1] ? (~number_in + 1'b1) : number_in;
         bcd_in = '0;
         cnt_in = '0;
      end else if (cmd.shift) begin
         bcd_in = {bcd_adj[BcdW-2:0], bin_ff[NumBits-1]};
         bin_in = {bin_ff[NumBits-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
      end else if (cmd.prep) begin
         idx_in = lead_idx;
      end else if (cmd.next_digit) begin
         idx_in = idx_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      idx_ff <= idx_in;
   end

   assign cur_digit = bcd_ff[idx_ff*DigitW +: DigitW];
   assign char_code = cmd.emit_sign ? AsciiMinus : AsciiZero + {3'b000, cur_digit};

   assign status.shift_done = (cnt_ff == StepLast);
   assign status.neg        = neg_ff;
   assign status.last_digit = (idx_ff == '0);

endmodule

[design/sidta_ctrl.sv]
`timescale 1ns / 1ps

module sidta_ctrl import sidta_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic          rsp_last,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CONVERT;
         end
         ST_CONVERT: begin
            if (status.shift_done) state_in = ST_PREP;
         end
         ST_PREP: begin
            state_in = status.neg ? ST_SIGN : ST_DIGITS;
         end
         ST_SIGN: begin
            if (rsp_ready) state_in = ST_DIGITS;
         end
         ST_DIGITS: begin
            if (rsp_ready && status.last_digit) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      rsp_last  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_CONVERT: begin
            cmd.shift = 1'b1;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
         end
         ST_SIGN: begin
            rsp_valid     = 1'b1;
            cmd.emit_sign = 1'b1;
         end
         ST_DIGITS: begin
            rsp_valid      = 1'b1;
            rsp_last       = status.last_digit;
            cmd.next_digit = rsp_ready && !status.last_digit;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[design/signed_int_to_decimal_ascii.sv]
`timescale 1ns / 1ps

// Signed 16-bit integer to decimal ASCII text.
// One item on the req_ stream carries a two's complement number. The block
// answers with one rsp_ item per character, most significant first: a minus
// sign when the number is negative, then the digits without leading zeros.
// Zero gives the single character '0', and -32768 gives "-32768". The last
// character of each number is marked by rsp_tlast.
// The number is converted to BCD by a shift-and-add-3 loop, one bit per
// cycle, in the ST_CONVERT state; the ST_PREP state then finds the leading
// digit. After that the characters are offered, and one character can leave
// per cycle while the receiver holds rsp_tready high.
// Only one number is worked on at a time; req_tready is high only while
// the block is idle. When the receiver holds rsp_tready low, the current
// character and its tlast stay on the port until taken.
// Reset is synchronous and active high; it returns the controller to idle
// and drops any number in progress.

module signed_int_to_decimal_ascii import sidta_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] number_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [6:0] char_code, [7] zero
   output logic        rsp_tlast    // last_char
);

   ctrl_cmd_type     cmd;
   dp_status_type    status;
   logic [CharW-1:0] char_code;

   sidta_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_last  (rsp_tlast),
      .status    (status),
      .cmd       (cmd)
   );

   sidta_dp u_dp (
      .clock     (clock),
      .number_in (req_tdata),
      .cmd       (cmd),
      .status    (status),
      .char_code (char_code)
   );

   // The character code sits in the low seven bits, padded to a byte.
   assign rsp_tdata = {1'b0, char_code};

endmodule
